// ===== src/haptic_pattern_sequencer_unit_macros.svh =====
// Assertion macros for the haptic pattern sequencer.
`ifndef HAPTIC_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define HAPTIC_PATTERN_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, off while reset is asserted.
`define HPS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("hps assertion failed");

// Next-cycle implication, off while reset is asserted.
`define HPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("hps assertion failed");

`else

`define HPS_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define HPS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/hps_pkg.sv =====
package hps_pkg;

    // Pattern codes; anything above PAT_SOS is unknown.
    localparam logic [2:0] PAT_SINGLE = 3'd0;
    localparam logic [2:0] PAT_DOUBLE = 3'd1;
    localparam logic [2:0] PAT_TRIPLE = 3'd2;
    localparam logic [2:0] PAT_LONG   = 3'd3;
    localparam logic [2:0] PAT_SOS    = 3'd4;

    // Item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_START = 1'b1;

    localparam logic [15:0] MIN_DURATION = 16'd50;

    // SOS Morse timing: dots, letter gap, dashes, letter gap, dots
    localparam int SOS_SEGS = 20;
    localparam logic [4:0] SOS_LAST = 5'(SOS_SEGS - 1);
    localparam logic [7:0] SOS_LEN [SOS_SEGS] = '{
        8'd80, 8'd80, 8'd80, 8'd80, 8'd80, 8'd80, 8'd160,
        8'd240, 8'd80, 8'd240, 8'd80, 8'd240, 8'd80, 8'd160,
        8'd80, 8'd80, 8'd80, 8'd80, 8'd80, 8'd80
    };
    // bit i set: segment i drives the motor
    localparam logic [SOS_SEGS-1:0] SOS_ON = 20'b0101_0100_1010_1001_0101;

    // One result item
    typedef struct packed {
        logic [7:0] motor_level;
        logic       led_on;
        logic       busy;
        logic       done;
        logic [2:0] done_pattern;
    } t_result;

endpackage

// ===== src/haptic_pattern_sequencer_unit.sv =====
// Channel   Direction  Handshake                 Payload
// input     in         i_in_valid / o_in_stall   func, pattern_code, duration_ms, level
// output    out        o_out_valid / i_out_stall motor_level, led_on, busy_res, done_res,
//                                                done_pattern
//
// One item per cycle unless the output stalls; stages: input register, result register.
// The duration clamp and the divide by 3 or 5 (one reciprocal multiply) sit in front of
// the input register; the segment countdown sits in front of the result register.
// Reset (synchronous, active low) empties both stages and clears all pattern state.
// An output stall holds the result; only it, with both stages full, stalls the input.

`include "haptic_pattern_sequencer_unit_macros.svh"

module haptic_pattern_sequencer_unit #(
    parameter int TIME_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [2:0]  i_pattern_code,
    input  logic [15:0] i_duration_ms,
    input  logic [7:0]  i_level,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_motor_level,
    output logic        o_led_on,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [2:0]  o_done_pattern
);
    import hps_pkg::*;

    localparam int TB = TIME_BITS;
    localparam int DW = (TB > 16) ? TB : 16;
    localparam logic [DW-1:0] TMAX = DW'({TB{1'b1}});
    // Reciprocals for exact x/3 and x/5 on TB-bit x, both with shift TB+2
    localparam logic [TB+2:0] P2 = {1'b1, {(TB+2){1'b0}}};
    localparam logic [TB:0]   M3 = (TB+1)'(P2 / 3 + 1);
    localparam logic [TB:0]   M5 = (TB+1)'(P2 / 5 + 1);

    // Segment length of a pattern; zero past its end
    function automatic logic [TB-1:0] f_seg_len(input logic [4:0] idx,
                                                input logic [2:0] pat,
                                                input logic [TB-1:0] pulse);
        logic [TB-1:0] len;
        len = '0;
        case (pat)
            PAT_SINGLE, PAT_LONG: begin
                if (idx == 5'd0) len = pulse;
            end
            PAT_DOUBLE: begin
                if (idx == 5'd1) len = pulse >> 1;
                else if (idx <= 5'd2) len = pulse;
            end
            PAT_TRIPLE: begin
                if (idx <= 5'd4) len = idx[0] ? (pulse >> 1) : pulse;
            end
            PAT_SOS: begin
                if (idx <= SOS_LAST) len = TB'(SOS_LEN[idx]);
            end
            default: len = '0;
        endcase
        return len;
    endfunction

    // Motor on during segment idx
    function automatic logic f_seg_on(input logic [4:0] idx, input logic [2:0] pat);
        logic on;
        on = 1'b0;
        case (pat)
            PAT_SINGLE, PAT_LONG: on = (idx == 5'd0);
            PAT_DOUBLE:           on = (idx == 5'd0) || (idx == 5'd2);
            PAT_TRIPLE:           on = (idx <= 5'd4) && !idx[0];
            PAT_SOS:              on = (idx <= SOS_LAST) && SOS_ON[idx];
            default:              on = 1'b0;
        endcase
        return on;
    endfunction

    // ---------------- handshake ----------------
    logic r_s1_v, r_out_v;
    logic s1_move, in_xfer, out_load;

    assign s1_move    = !r_out_v || !i_out_stall;
    assign o_in_stall = r_s1_v && !s1_move;
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign out_load   = r_s1_v && s1_move;
    assign o_out_valid = r_out_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (in_xfer) r_s1_v <= 1'b1;
            else if (s1_move) r_s1_v <= 1'b0;
            if (out_load) r_out_v <= 1'b1;
            else if (!i_out_stall) r_out_v <= 1'b0;
        end
    end

    // ---------------- input stage: clamp and pulse length ----------------
    logic [15:0]     dur_min;
    logic [DW-1:0]   dur_ext;
    logic [TB-1:0]   dur_sat;
    logic [TB:0]     recip;
    logic [2*TB:0]   prod;
    logic [TB-1:0]   in_pulse;

    always_comb begin
        dur_min = (i_duration_ms < MIN_DURATION) ? MIN_DURATION : i_duration_ms;
        dur_ext = DW'(dur_min);
        dur_sat = TB'((dur_ext > TMAX) ? TMAX : dur_ext);
        recip   = (i_pattern_code == PAT_TRIPLE) ? M5 : M3;
        prod    = (2*TB+1)'(dur_sat) * (2*TB+1)'(recip);
        if (i_pattern_code == PAT_DOUBLE || i_pattern_code == PAT_TRIPLE)
            in_pulse = TB'(prod >> (TB + 2));
        else
            in_pulse = dur_sat;
    end

    logic          r_s1_func;
    logic [2:0]    r_s1_code;
    logic [TB-1:0] r_s1_pulse;
    logic [7:0]    r_s1_level;

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_func  <= i_func;
            r_s1_code  <= i_pattern_code;
            r_s1_pulse <= in_pulse;
            r_s1_level <= i_level;
        end
    end

    // ---------------- pattern state ----------------
    logic          r_playing, n_playing;
    logic [2:0]    r_cur_pat, n_cur_pat;
    logic [4:0]    r_seg, n_seg;
    logic [TB-1:0] r_remaining, n_remaining;
    logic [TB-1:0] r_pulse, n_pulse;
    logic [7:0]    r_active, n_active;
    logic          r_pend_v, n_pend_v;
    logic [2:0]    r_pend_pat, n_pend_pat;
    logic [TB-1:0] r_pend_pulse, n_pend_pulse;
    logic [7:0]    r_pend_level, n_pend_level;

    logic [TB-1:0] rem_dec, nxt_len;
    logic [4:0]    seg_nx;
    t_result       res;

    // Next state for the item in the input register
    always_comb begin
        n_playing    = r_playing;
        n_cur_pat    = r_cur_pat;
        n_seg        = r_seg;
        n_remaining  = r_remaining;
        n_pulse      = r_pulse;
        n_active     = r_active;
        n_pend_v     = r_pend_v;
        n_pend_pat   = r_pend_pat;
        n_pend_pulse = r_pend_pulse;
        n_pend_level = r_pend_level;
        rem_dec      = r_remaining - TB'(r_remaining != '0);
        seg_nx       = r_seg + 5'd1;
        nxt_len      = f_seg_len(seg_nx, r_cur_pat, r_pulse);
        res          = '0;

        if (r_s1_func == FUNC_START) begin
            n_pend_v     = 1'b1;
            n_pend_pat   = r_s1_code;
            n_pend_pulse = r_s1_pulse;
            n_pend_level = r_s1_level;
            if (!r_playing) begin
                n_pend_v = 1'b0;
                if (r_s1_code > PAT_SOS) begin
                    // unknown code finishes on the spot
                    res.done         = 1'b1;
                    res.done_pattern = r_s1_code;
                end else begin
                    n_playing   = 1'b1;
                    n_cur_pat   = r_s1_code;
                    n_active    = r_s1_level;
                    n_pulse     = r_s1_pulse;
                    n_seg       = 5'd0;
                    n_remaining = f_seg_len(5'd0, r_s1_code, r_s1_pulse);
                end
            end
        end else if (r_playing) begin
            n_remaining = rem_dec;
            if (rem_dec == '0) begin
                n_seg = seg_nx;
                if (nxt_len == '0) begin
                    // pattern ends; a pending job with a known code takes over
                    n_playing        = 1'b0;
                    res.done         = 1'b1;
                    res.done_pattern = r_cur_pat;
                    if (r_pend_v) begin
                        n_pend_v = 1'b0;
                        if (r_pend_pat <= PAT_SOS) begin
                            n_playing   = 1'b1;
                            n_cur_pat   = r_pend_pat;
                            n_active    = r_pend_level;
                            n_pulse     = r_pend_pulse;
                            n_seg       = 5'd0;
                            n_remaining = f_seg_len(5'd0, r_pend_pat, r_pend_pulse);
                        end
                    end
                end else begin
                    n_remaining = nxt_len;
                end
            end
        end

        res.busy        = n_playing;
        res.led_on      = n_playing && f_seg_on(n_seg, n_cur_pat);
        res.motor_level = res.led_on ? n_active : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_playing    <= 1'b0;
            r_cur_pat    <= 3'd0;
            r_seg        <= 5'd0;
            r_remaining  <= '0;
            r_pulse      <= '0;
            r_active     <= 8'd0;
            r_pend_v     <= 1'b0;
            r_pend_pat   <= 3'd0;
            r_pend_pulse <= '0;
            r_pend_level <= 8'd0;
        end else if (out_load) begin
            r_playing    <= n_playing;
            r_cur_pat    <= n_cur_pat;
            r_seg        <= n_seg;
            r_remaining  <= n_remaining;
            r_pulse      <= n_pulse;
            r_active     <= n_active;
            r_pend_v     <= n_pend_v;
            r_pend_pat   <= n_pend_pat;
            r_pend_pulse <= n_pend_pulse;
            r_pend_level <= n_pend_level;
        end
    end

    // ---------------- result register ----------------
    t_result r_res;

    always_ff @(posedge i_clk) begin
        if (out_load) r_res <= res;
    end

    assign o_motor_level  = r_res.motor_level;
    assign o_led_on       = r_res.led_on;
    assign o_busy_res     = r_res.busy;
    assign o_done_res     = r_res.done;
    assign o_done_pattern = r_res.done_pattern;

    // ---------------- checks ----------------
    `HPS_ASSERT_NOW(a_play_has_time, i_clk, i_rst_n, r_playing, r_remaining != '0)
    `HPS_ASSERT_NOW(a_play_known, i_clk, i_rst_n, r_playing, r_cur_pat <= PAT_SOS)
    `HPS_ASSERT_NOW(a_led_busy, i_clk, i_rst_n, r_out_v && r_res.led_on, r_res.busy)
    `HPS_ASSERT_NOW(a_off_silent, i_clk, i_rst_n, r_out_v && !r_res.led_on,
                    r_res.motor_level == 8'd0)
    `HPS_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !out_load,
                     $stable(r_playing) && $stable(r_remaining) && $stable(r_pend_v))

endmodule
